@@ rtl/set_assoc_cache_lru_sim_unit_defines.svh @@
// Assertion macros shared by the cache simulator RTL.
`ifndef SET_ASSOC_CACHE_LRU_SIM_UNIT_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_SIM_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SACL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sacl: same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SACL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sacl: next-cycle check failed");

`endif

@@ rtl/sacl_pkg.sv @@
// Shared types, codes and helpers of the cache simulator.
package sacl_pkg;

    localparam int ADDR_W = 64;
    localparam int CNT_W  = 32;

    // Trace entry kinds.
    localparam logic [1:0] ACT_IGNORE = 2'd0;
    localparam logic [1:0] ACT_SINGLE = 2'd1;
    localparam logic [1:0] ACT_MODIFY = 2'd2;

    // Access outcomes.
    localparam logic [1:0] OC_HIT   = 2'd0;
    localparam logic [1:0] OC_FILL  = 2'd1;
    localparam logic [1:0] OC_EVICT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS_USED   = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [3:0]       WAYS_RESET = 4'd8;
    localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

    // Depth of the queue between front and back; a power of two.
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [3:0] set_bits;
        logic [4:0] offset_bits;
        logic [3:0] ways_used;
    } t_cfg;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

@@ rtl/sacl_in_if.sv @@
// Trace entry channel: valid/ready handshake with action and address.
interface sacl_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [sacl_pkg::ADDR_W-1:0] address;

    modport source (output valid, action, address, input ready);
    modport sink   (input valid, action, address, output ready);
endinterface

@@ rtl/sacl_out_if.sv @@
// Result channel: valid/ready handshake with outcome and running counts.
interface sacl_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 outcome;
    logic                       last;
    logic [sacl_pkg::CNT_W-1:0] hit_total;
    logic [sacl_pkg::CNT_W-1:0] miss_total;
    logic [sacl_pkg::CNT_W-1:0] evict_total;

    modport source (output valid, outcome, last, hit_total, miss_total, evict_total,
                    input ready);
    modport sink   (input valid, outcome, last, hit_total, miss_total, evict_total,
                    output ready);
endinterface

@@ rtl/sacl_front.sv @@
// Front end: accepts trace entries, drops ignores, splits the address.
module sacl_front #(
    parameter int MAX_SET_BITS = 8,
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    localparam int ENT_W = SET_W + sacl_pkg::ADDR_W + 1
) (
    sacl_in_if.sink     i_req,
    input  logic [3:0]  i_set_bits,
    input  logic [4:0]  i_offset_bits,
    input  logic        i_q_full,
    input  logic        i_block,
    output logic        o_push,
    output logic [ENT_W-1:0] o_data
);

    logic [3:0]                  sb;
    logic [sacl_pkg::ADDR_W-1:0] shifted;
    logic [sacl_pkg::ADDR_W-1:0] tag;
    logic [SET_W-1:0]            mask;
    logic [SET_W-1:0]            idx;
    logic                        is_access;
    logic                        is_modify;

    always_comb begin
        sb = (i_set_bits > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : i_set_bits;
        shifted = i_req.address >> i_offset_bits;
        tag = shifted >> sb;
        for (int b = 0; b < SET_W; b++) begin
            mask[b] = (4'(b) < sb);
        end
        idx = shifted[SET_W-1:0] & mask;
    end

    assign is_modify   = (i_req.action == sacl_pkg::ACT_MODIFY);
    assign is_access   = (i_req.action == sacl_pkg::ACT_SINGLE) || is_modify;
    assign i_req.ready = !i_q_full && !i_block;
    assign o_push      = i_req.valid && i_req.ready && is_access;
    assign o_data      = {is_modify, idx, tag};

endmodule

@@ rtl/sacl_fifo.sv @@
// Short queue that decouples the front end from the cache engine.
module sacl_fifo #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);

    localparam int PTR_W = (sacl_pkg::Q_DEPTH > 1) ? $clog2(sacl_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(sacl_pkg::Q_DEPTH + 1);

    logic [DW-1:0]    r_slot [sacl_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(sacl_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/sacl_back.sv @@
// Cache engine: set memory, clearing pass, lookup, LRU update and counters.
module sacl_back #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS = 8,
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    localparam int ENT_W = SET_W + sacl_pkg::ADDR_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [3:0]       i_ways_used,
    input  logic             i_q_valid,
    input  logic [ENT_W-1:0] i_q_data,
    output logic             o_q_pop,
    output logic             o_clearing,
    sacl_out_if.source       o_res
);

    localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int MEM_DEPTH = 1 << SET_W;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    typedef struct packed {
        logic [MAX_WAYS-1:0]                            valid;
        logic [MAX_WAYS-1:0][RANK_W-1:0]                rank;
        logic [MAX_WAYS-1:0][sacl_pkg::ADDR_W-1:0]      tag;
    } t_row;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EVAL  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    t_row r_mem [MEM_DEPTH];
    t_row r_rd_row;
    t_row r_row;
    t_row row_src;
    t_row new_row;

    logic [SET_W-1:0] r_clr_cnt;
    logic             r_second;

    logic [sacl_pkg::CNT_W-1:0] r_hit;
    logic [sacl_pkg::CNT_W-1:0] r_miss;
    logic [sacl_pkg::CNT_W-1:0] r_evict;
    logic [sacl_pkg::CNT_W-1:0] n_hit;
    logic [sacl_pkg::CNT_W-1:0] n_miss;
    logic [sacl_pkg::CNT_W-1:0] n_evict;

    logic                       r_out_valid;
    logic [1:0]                 r_out_outcome;
    logic                       r_out_last;

    logic [sacl_pkg::ADDR_W-1:0] q_tag;
    logic [SET_W-1:0]            q_idx;
    logic                        q_modify;

    logic [4:0]          ways_eff;
    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] inv_vec;
    logic [MAX_WAYS-1:0] hit_oh;
    logic [MAX_WAYS-1:0] inv_oh;
    logic [MAX_WAYS-1:0] vic_oh;
    logic [MAX_WAYS-1:0] tgt_oh;
    logic [RANK_W-1:0]   best;
    logic [RANK_W-1:0]   lim;
    logic                found;
    logic                is_hit;
    logic                is_fill;
    logic [1:0]          outcome;
    logic                more;
    logic                fire;
    logic                mem_re;
    logic                mem_we;
    logic [SET_W-1:0]    mem_wa;
    t_row                mem_wd;

    assign q_tag    = i_q_data[sacl_pkg::ADDR_W-1:0];
    assign q_idx    = i_q_data[sacl_pkg::ADDR_W +: SET_W];
    assign q_modify = i_q_data[ENT_W-1];

    // The second access of a modify works on the row the first one left.
    assign row_src = r_second ? r_row : r_rd_row;

    always_comb begin
        if (i_ways_used == 4'd0) begin
            ways_eff = 5'd1;
        end else if ({1'b0, i_ways_used} > 5'(MAX_WAYS)) begin
            ways_eff = 5'(MAX_WAYS);
        end else begin
            ways_eff = {1'b0, i_ways_used};
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w]  = (5'(w) < ways_eff);
            hit_vec[w] = in_use[w] && row_src.valid[w] && (row_src.tag[w] == q_tag);
            inv_vec[w] = in_use[w] && !row_src.valid[w];
        end
        hit_oh = hit_vec & (~hit_vec + MAX_WAYS'(1));
        inv_oh = inv_vec & (~inv_vec + MAX_WAYS'(1));

        // Oldest way in use; the lowest index wins a tie.
        found  = 1'b0;
        best   = '0;
        vic_oh = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (in_use[w] && (!found || row_src.rank[w] > best)) begin
                found     = 1'b1;
                best      = row_src.rank[w];
                vic_oh    = '0;
                vic_oh[w] = 1'b1;
            end
        end

        is_hit  = |hit_vec;
        is_fill = !is_hit && |inv_vec;
        if (is_hit) begin
            tgt_oh  = hit_oh;
            outcome = sacl_pkg::OC_HIT;
        end else if (is_fill) begin
            tgt_oh  = inv_oh;
            outcome = sacl_pkg::OC_FILL;
        end else begin
            tgt_oh  = vic_oh;
            outcome = sacl_pkg::OC_EVICT;
        end

        lim = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (tgt_oh[w]) begin
                lim = lim | row_src.rank[w];
            end
        end

        // Valid lines younger than the touched one age; on a fill all of them do.
        new_row = row_src;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (in_use[w] && row_src.valid[w] && (is_fill || row_src.rank[w] < lim) &&
                row_src.rank[w] != RANK_MAX) begin
                new_row.rank[w] = row_src.rank[w] + RANK_W'(1);
            end
            if (tgt_oh[w]) begin
                new_row.valid[w] = 1'b1;
                new_row.tag[w]   = q_tag;
                new_row.rank[w]  = '0;
            end
        end

        n_hit   = is_hit ? sacl_pkg::sat_inc(r_hit) : r_hit;
        n_miss  = is_hit ? r_miss : sacl_pkg::sat_inc(r_miss);
        n_evict = (outcome == sacl_pkg::OC_EVICT) ? sacl_pkg::sat_inc(r_evict) : r_evict;
    end

    assign fire    = (r_state == S_EVAL) && (!r_out_valid || o_res.ready);
    assign more    = q_modify && !r_second;
    assign o_q_pop = fire && !more;
    assign mem_re  = (r_state == S_IDLE) && i_q_valid;
    assign mem_we  = (r_state == S_CLEAR) || fire;
    assign mem_wa  = (r_state == S_CLEAR) ? r_clr_cnt : q_idx;
    assign mem_wd  = (r_state == S_CLEAR) ? t_row'('0) : new_row;

    assign o_clearing = (r_state == S_CLEAR);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (&r_clr_cnt) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (fire && !more) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_row <= r_mem[q_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_row         <= new_row;
            r_out_outcome <= outcome;
            r_out_last    <= !more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_second    <= 1'b0;
            r_hit       <= '0;
            r_miss      <= '0;
            r_evict     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + SET_W'(1);
            end
            if (fire) begin
                r_second    <= more;
                r_hit       <= n_hit;
                r_miss      <= n_miss;
                r_evict     <= n_evict;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.outcome     = r_out_outcome;
    assign o_res.last        = r_out_last;
    assign o_res.hit_total   = r_hit;
    assign o_res.miss_total  = r_miss;
    assign o_res.evict_total = r_evict;

endmodule

@@ rtl/set_assoc_cache_lru_sim_unit.sv @@
// Top level of the set-associative LRU cache simulator.
// This block replays a memory trace against a set-associative cache model with
// least-recently-used replacement and reports, for every access, whether it hit,
// filled an empty line or evicted one, together with saturating running counts
// of hits, misses and evictions. A trace entry of kind single makes one access
// and one result beat; a modify makes two accesses to the same address and two
// beats, the second flagged as last; an ignore entry is taken and dropped with
// no result and no aging. The address is cut into block offset, set index and
// a full-width tag by the configured bit counts. Each access reads, updates and
// writes back one set row in the set memory: the idle state reads the row, the
// evaluate state looks it up, updates the ranks and writes it back once the
// output register is free, and a modify runs its second lookup on the updated
// row held in a register. A two-entry queue sits between the entry decoder and
// the cache engine, and the result beat is held in an output register, so the
// input side keeps taking entries while a result waits. After reset the engine
// sweeps the set memory once, one row per cycle, over all 2**MAX_SET_BITS rows
// (two for MAX_SET_BITS of zero); no entry is taken until the sweep is
// done, while configuration writes are accepted at any time. Configuration must
// only be changed while no result is outstanding.
module set_assoc_cache_lru_sim_unit #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    sacl_in_if.sink                             i_req,
    sacl_out_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

`include "set_assoc_cache_lru_sim_unit_defines.svh"

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ENT_W = SET_W + sacl_pkg::ADDR_W + 1;

    sacl_pkg::t_cfg r_cfg;

    logic             q_push;
    logic [ENT_W-1:0] q_wdata;
    logic             q_full;
    logic             q_valid;
    logic [ENT_W-1:0] q_rdata;
    logic             q_pop;
    logic             clearing;

    // Configuration registers; writes to an unknown index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits    <= 4'd0;
            r_cfg.offset_bits <= 5'd0;
            r_cfg.ways_used   <= sacl_pkg::WAYS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sacl_pkg::CFG_SET_BITS:    r_cfg.set_bits    <= i_cfg_data[3:0];
                sacl_pkg::CFG_OFFSET_BITS: r_cfg.offset_bits <= i_cfg_data[4:0];
                sacl_pkg::CFG_WAYS_USED:   r_cfg.ways_used   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // The decoder drops ignore entries and queues accesses with their set and tag.
    sacl_front #(
        .MAX_SET_BITS (MAX_SET_BITS)
    ) u_front (
        .i_req         (i_req),
        .i_set_bits    (r_cfg.set_bits),
        .i_offset_bits (r_cfg.offset_bits),
        .i_q_full      (q_full),
        .i_block       (clearing),
        .o_push        (q_push),
        .o_data        (q_wdata)
    );

    sacl_fifo #(
        .DW (ENT_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    // The engine pops an entry only when its last access is issued.
    sacl_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ways_used (r_cfg.ways_used),
        .i_q_valid   (q_valid),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_res       (o_res)
    );

    // No entry may enter while the set memory is still being swept.
    `SACL_ASSERT_IMP(a_no_take_in_clear, i_clk, i_rst_n, clearing, !i_req.ready)
    // The decoder never pushes into a full queue.
    `SACL_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, q_full, !q_push)
    // An eviction result always carries a nonzero eviction count.
    `SACL_ASSERT_IMP(a_evict_counted, i_clk, i_rst_n,
                     o_res.valid && (o_res.outcome == sacl_pkg::OC_EVICT),
                     o_res.evict_total != '0)
    // A miss result always carries a nonzero miss count.
    `SACL_ASSERT_IMP(a_miss_counted, i_clk, i_rst_n,
                     o_res.valid && (o_res.outcome != sacl_pkg::OC_HIT),
                     o_res.miss_total != '0)

endmodule
